@@ sv/frt_pkg.sv @@
package frt_pkg;

  localparam int NUM_CONTEXTS  = 16;
  localparam int MAX_FRAGMENTS = 64;
  localparam int SLOT_W        = $clog2(NUM_CONTEXTS);
  localparam int OPEN_W        = $clog2(NUM_CONTEXTS + 1);

  localparam logic [1:0] FUNC_FRAG  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_SWEEP = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_BAD_HDR  = 3'd2;
  localparam logic [2:0] ST_INCONS   = 3'd3;
  localparam logic [2:0] ST_DUP      = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_TICK     = 3'd6;
  localparam logic [2:0] ST_CLEARED  = 3'd7;

  localparam logic [1:0] REG_MAGIC   = 2'd0;
  localparam logic [1:0] REG_STRIDE  = 2'd1;
  localparam logic [1:0] REG_MAXMSG  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] header_magic;
    logic [15:0] frag_seq;
    logic [15:0] frag_total;
    logic [31:0] msg_bytes;
    logic [63:0] topic_key;
    logic [31:0] group_key;
    logic [15:0] payload_len;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [22:0] write_offset;
    logic [15:0] copy_bytes;
    logic [63:0] done_topic;
    logic [20:0] done_bytes;
    logic [31:0] complete_count;
    logic [31:0] timeout_count;
    logic [31:0] duplicate_count;
    logic [4:0]  open_groups;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic [1:0]  func;
    logic        bad;
    logic [15:0] frag_seq;
    logic [6:0]  frag_total;
    logic [20:0] msg_bytes;
    logic [63:0] topic_key;
    logic [31:0] group_key;
    logic [15:0] payload_len;
    logic [22:0] offset;
  } cmd_t;

endpackage

@@ sv/frt_front.sv @@
module frt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  frt_pkg::in_item_t in_data,
  input  logic [31:0]       magic_value,
  input  logic [15:0]       frag_payload_bytes,
  input  logic [20:0]       max_msg_bytes,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output frt_pkg::cmd_t     cmd
);
  import frt_pkg::*;

  // two-entry queue between front and back
  cmd_t        q_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  cmd_t        c;
  logic        push_ok, pop_ok;
  logic [31:0] prod;

  assign in_full   = (cnt_r == 2'd2);
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop_ok    = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  // header checks and offset
  always_comb begin
    prod = 32'(in_data.frag_seq) * 32'(frag_payload_bytes);
    c.func        = in_data.func;
    c.bad         = (in_data.header_magic != magic_value) || (in_data.frag_total == 16'd0)
                 || (in_data.frag_total > 16'(MAX_FRAGMENTS))
                 || (in_data.frag_seq >= in_data.frag_total)
                 || (in_data.msg_bytes > 32'(max_msg_bytes));
    c.frag_seq    = in_data.frag_seq;
    c.frag_total  = in_data.frag_total[6:0];
    c.msg_bytes   = in_data.msg_bytes[20:0];
    c.topic_key   = in_data.topic_key;
    c.group_key   = in_data.group_key;
    c.payload_len = in_data.payload_len;
    c.offset      = prod[22:0];
  end

  always_comb begin
    wp_nxt  = wp_r ^ push_ok;
    rp_nxt  = rp_r ^ pop_ok;
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
    if (push_ok) q_r[wp_r] <= c;
  end
endmodule

@@ sv/frt_back.sv @@
module frt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  frt_pkg::cmd_t      cmd,
  input  logic [31:0]        timeout_ticks,
  output logic               out_empty,
  input  logic               out_pop,
  output frt_pkg::out_item_t out_data
);
  import frt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WORK = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   c_r;
  logic   [NUM_CONTEXTS-1:0] valid_r;
  logic   [63:0] topic_r [NUM_CONTEXTS];
  logic   [31:0] group_r [NUM_CONTEXTS];
  logic   [6:0]  total_r [NUM_CONTEXTS];
  logic   [20:0] bytes_r [NUM_CONTEXTS];
  logic   [6:0]  got_r   [NUM_CONTEXTS];
  logic   [63:0] map_r   [NUM_CONTEXTS];
  logic   [31:0] born_r  [NUM_CONTEXTS];
  logic   [NUM_CONTEXTS-1:0] hit_r, hit_nxt, exp_r, exp_nxt;
  logic   [31:0] now_r, ccnt_r, tcnt_r, dcnt_r;
  logic   [OPEN_W-1:0] open_r;
  out_item_t res_r;
  logic   res_v_r;

  // match and age flags, registered before the update
  always_comb begin
    for (int i = 0; i < NUM_CONTEXTS; i++) begin
      hit_nxt[i] = valid_r[i] && topic_r[i] == cmd.topic_key && group_r[i] == cmd.group_key;
      exp_nxt[i] = valid_r[i] && (now_r - born_r[i]) > timeout_ticks;
    end
  end

  assign cmd_ready = (state_r == S_IDLE);
  assign out_empty = !res_v_r;
  assign out_data  = res_r;

  logic [SLOT_W-1:0] hs, fs;
  logic hf, ff;
  logic [4:0] nexp;
  always_comb begin
    hs = '0; hf = 1'b0; fs = '0; ff = 1'b0; nexp = '0;
    for (int i = NUM_CONTEXTS - 1; i >= 0; i--) begin
      if (hit_r[i])   begin hs = SLOT_W'(i); hf = 1'b1; end
      if (!valid_r[i]) begin fs = SLOT_W'(i); ff = 1'b1; end
    end
    for (int i = 0; i < NUM_CONTEXTS; i++) nexp = nexp + 5'(exp_r[i]);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (cmd_valid) state_nxt = S_WORK;
      S_WORK:  state_nxt = S_OUT;
      S_OUT:   if (!res_v_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // fragment update work
  logic [SLOT_W-1:0] s;
  logic [63:0] bit_m;
  logic [32:0] room;
  out_item_t r;
  always_comb begin
    s = hf ? hs : fs;
    bit_m = 64'd1 << c_r.frag_seq[5:0];
    room  = {12'd0, c_r.msg_bytes} - {10'd0, c_r.offset};
    r = '0;
    r.slot = 4'(s);
  end

  logic [31:0] ccnt_nxt, tcnt_nxt, dcnt_nxt, tsum;
  logic [OPEN_W-1:0] open_nxt;
  out_item_t rn;
  logic [6:0] tot_s, got_s;
  logic [63:0] map_s;
  logic [20:0] byt_s;
  always_comb begin
    ccnt_nxt = ccnt_r; tcnt_nxt = tcnt_r; dcnt_nxt = dcnt_r; open_nxt = open_r;
    rn = r;
    tot_s = hf ? total_r[s] : c_r.frag_total;
    byt_s = hf ? bytes_r[s] : c_r.msg_bytes;
    got_s = hf ? got_r[s] : 7'd0;
    map_s = hf ? map_r[s] : 64'd0;
    tsum = tcnt_r + 32'(nexp);
    case (c_r.func)
      FUNC_TICK: begin rn.status = ST_TICK; rn.slot = '0; end
      FUNC_SWEEP: begin
        rn.status = ST_TICK; rn.slot = '0;
        tcnt_nxt = (tsum < tcnt_r) ? 32'hFFFF_FFFF : tsum;
        open_nxt = open_r - OPEN_W'(nexp);
      end
      FUNC_CLEAR: begin
        rn.status = ST_CLEARED; rn.slot = '0;
        ccnt_nxt = '0; tcnt_nxt = '0; dcnt_nxt = '0; open_nxt = '0;
      end
      default: begin
        if (c_r.bad) begin rn.status = ST_BAD_HDR; rn.slot = '0; end
        else if (!hf && !ff) begin rn.status = ST_FULL; rn.slot = '0; end
        else begin
          if (!hf) open_nxt = open_r + OPEN_W'(1);
          if (tot_s != c_r.frag_total || byt_s != c_r.msg_bytes) rn.status = ST_INCONS;
          else if ((map_s & bit_m) != 0) begin
            rn.status = ST_DUP;
            if (dcnt_r != 32'hFFFF_FFFF) dcnt_nxt = dcnt_r + 32'd1;
          end else begin
            rn.write_offset = c_r.offset;
            rn.copy_bytes = room[32] || room == 0 ? 16'd0 :
                            (33'(c_r.payload_len) < room ? c_r.payload_len : room[15:0]);
            if (got_s + 7'd1 == tot_s) begin
              rn.status = ST_COMPLETE;
              rn.done_topic = c_r.topic_key;
              rn.done_bytes = byt_s;
              open_nxt = open_nxt - OPEN_W'(1);
              if (ccnt_r != 32'hFFFF_FFFF) ccnt_nxt = ccnt_r + 32'd1;
            end else rn.status = ST_STORED;
          end
        end
      end
    endcase
    rn.complete_count  = ccnt_nxt;
    rn.timeout_count   = tcnt_nxt;
    rn.duplicate_count = dcnt_nxt;
    rn.open_groups     = 5'(open_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= '0; now_r <= '0; res_v_r <= 1'b0;
      ccnt_r <= '0; tcnt_r <= '0; dcnt_r <= '0; open_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_pop && res_v_r) res_v_r <= 1'b0;
      if (state_r == S_WORK) begin
        res_v_r <= 1'b1;
        ccnt_r <= ccnt_nxt; tcnt_r <= tcnt_nxt; dcnt_r <= dcnt_nxt; open_r <= open_nxt;
        case (c_r.func)
          FUNC_TICK:  now_r <= now_r + 32'd1;
          FUNC_SWEEP: valid_r <= valid_r & ~exp_r;
          FUNC_CLEAR: valid_r <= '0;
          default: begin
            if (!c_r.bad && (hf || ff)) begin
              valid_r[s] <= !(rn.status == ST_COMPLETE);
              if (!hf) begin
                topic_r[s] <= c_r.topic_key; group_r[s] <= c_r.group_key;
                total_r[s] <= c_r.frag_total; bytes_r[s] <= c_r.msg_bytes;
                born_r[s] <= now_r;
              end
              got_r[s] <= (rn.status == ST_STORED || rn.status == ST_COMPLETE)
                          ? got_s + 7'd1 : got_s;
              map_r[s] <= (rn.status == ST_STORED || rn.status == ST_COMPLETE)
                          ? (map_s | bit_m) : map_s;
            end
          end
        endcase
      end
    end
    if (state_r == S_IDLE && cmd_valid) begin
      c_r <= cmd; hit_r <= hit_nxt; exp_r <= exp_nxt;
    end
    if (state_r == S_WORK) res_r <= rn;
  end
endmodule

@@ sv/fragment_reassembly_tracker.sv @@
// Fragment reassembly tracker: 16 contexts keyed by topic and group. An item
// is checked by the front end and queued; the back end registers the match and
// age flags, updates the table and registers the result in the next cycle,
// holds until the result is popped and only then returns to idle to take the
// next item. A front queue of two lets items arrive meanwhile.
module fragment_reassembly_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  frt_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output frt_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import frt_pkg::*;

  logic [31:0] magic_r, timeout_r;
  logic [15:0] stride_r;
  logic [20:0] maxmsg_r;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0; stride_r <= 16'd1400; maxmsg_r <= 21'd65536; timeout_r <= 32'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAGIC:   magic_r   <= cfg_data;
        REG_STRIDE:  stride_r  <= cfg_data[15:0];
        REG_MAXMSG:  maxmsg_r  <= cfg_data[20:0];
        REG_TIMEOUT: timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  frt_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .magic_value(magic_r), .frag_payload_bytes(stride_r), .max_msg_bytes(maxmsg_r),
    .cmd_valid, .cmd_ready, .cmd
  );

  frt_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .timeout_ticks(timeout_r),
    .out_empty, .out_pop, .out_data
  );
endmodule
